// ----- hw/rtl/mrd_pkg.sv -----
// ----------------------------------------------------------------------------
// mrd_pkg
// Shared types, constants and the CRC-16 byte update for the RTU deframer.
// ----------------------------------------------------------------------------
package mrd_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned PosW   = 9;
	localparam int unsigned FnW    = 7;
	localparam int unsigned CrcW   = 16;
	localparam int unsigned LimitW = 9;

	localparam logic [CrcW-1:0]   CRC_INIT    = 16'hFFFF;
	localparam logic [CrcW-1:0]   CRC_POLY    = 16'hA001;
	localparam logic [LimitW-1:0] LIMIT_RESET = 9'd256;
	localparam logic [LimitW-1:0] LIMIT_MIN   = 9'd3;
	localparam logic [PosW-1:0]   LEN_EXC     = 9'd5;
	localparam logic [PosW-1:0]   LEN_FIXED   = 9'd8;
	localparam logic [PosW-1:0]   LEN_OVERHEAD = 9'd5;

	localparam logic [FnW-1:0] FN_READ_COILS      = 7'h01;
	localparam logic [FnW-1:0] FN_READ_INPUTS     = 7'h04;
	localparam logic [FnW-1:0] FN_WRITE_COIL      = 7'h05;
	localparam logic [FnW-1:0] FN_WRITE_REG       = 7'h06;
	localparam logic [FnW-1:0] FN_WRITE_COILS     = 7'h0F;
	localparam logic [FnW-1:0] FN_WRITE_REGS      = 7'h10;

	typedef enum logic [2:0] {
		ST_PROGRESS = 3'd0,
		ST_OK       = 3'd1,
		ST_EXC_OK   = 3'd2,
		ST_CRC_ERR  = 3'd3,
		ST_UNKNOWN  = 3'd4
	} status_t;

	typedef struct packed {
		logic [ByteW-1:0] byte_out;
		logic [PosW-1:0]  byte_index;
		logic             frame_last;
		status_t          frame_status;
		logic [ByteW-1:0] slave_address;
		logic [FnW-1:0]   function_code;
		logic             exception_flag;
	} result_t;

	function automatic logic fn_fixed_len(input logic [FnW-1:0] fn);
		logic hit;
		case (fn)
			FN_WRITE_COIL, FN_WRITE_REG, FN_WRITE_COILS, FN_WRITE_REGS: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc_in,
		input logic [ByteW-1:0] data);
		logic [CrcW-1:0] c;
		c = crc_in ^ {{(CrcW-ByteW){1'b0}}, data};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- hw/rtl/mrd_frame.sv -----
// ----------------------------------------------------------------------------
// mrd_frame
// Frame tracking state, length decode, CRC check and per-byte result.
// ----------------------------------------------------------------------------
module mrd_frame
	import mrd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [ByteW-1:0]  rx_byte,
	input  logic              restart,
	input  logic [LimitW-1:0] limit,
	output result_t           res
);

	logic [PosW-1:0]  pos_q;
	logic [PosW-1:0]  exp_q;
	logic [CrcW-1:0]  crc_q;
	logic [ByteW-1:0] slave_q;
	logic [FnW-1:0]   fn_q;
	logic             exc_q;
	logic [ByteW-1:0] crclo_q;

	logic [PosW-1:0]  pos;
	logic [PosW-1:0]  exp_n;
	logic [CrcW-1:0]  crc_b;
	logic [CrcW-1:0]  crc_n;
	logic [ByteW-1:0] slave_n;
	logic [FnW-1:0]   fn_n;
	logic             exc_n;
	logic [ByteW-1:0] crclo_b;
	logic [ByteW-1:0] crclo_n;
	logic             known;
	logic [LimitW-1:0] limit_eff;
	logic [PosW:0]    pos_plus2;
	logic             last;
	status_t          status;

	always_comb begin
		pos     = restart ? '0 : pos_q;
		exp_n   = restart ? '0 : exp_q;
		crc_b   = restart ? CRC_INIT : crc_q;
		slave_n = restart ? '0 : slave_q;
		fn_n    = restart ? '0 : fn_q;
		exc_n   = restart ? 1'b0 : exc_q;
		crclo_b = restart ? '0 : crclo_q;

		if (pos == PosW'(0)) begin
			slave_n = rx_byte;
		end else if (pos == PosW'(1)) begin
			fn_n  = rx_byte[FnW-1:0];
			exc_n = rx_byte[ByteW-1];
			if (exc_n) begin
				exp_n = LEN_EXC;
			end else if (fn_fixed_len(fn_n)) begin
				exp_n = LEN_FIXED;
			end
		end else if (pos == PosW'(2)) begin
			if (!exc_n && fn_n >= FN_READ_COILS && fn_n <= FN_READ_INPUTS) begin
				exp_n = {{(PosW-ByteW){1'b0}}, rx_byte} + LEN_OVERHEAD;
			end
		end

		known = exc_n || fn_fixed_len(fn_n) ||
			(fn_n >= FN_READ_COILS && fn_n <= FN_READ_INPUTS);
		limit_eff = (limit < LIMIT_MIN) ? LIMIT_MIN : limit;
		pos_plus2 = {1'b0, pos} + (PosW+1)'(2);

		last    = 1'b0;
		status  = ST_PROGRESS;
		crc_n   = crc_b;
		crclo_n = crclo_b;

		if (pos != PosW'(0) && !known) begin
			if (pos >= limit_eff) begin
				last   = 1'b1;
				status = ST_UNKNOWN;
			end
		end else if (exp_n != '0 && pos_plus2 >= {1'b0, exp_n}) begin
			if (pos_plus2 == {1'b0, exp_n}) begin
				crclo_n = rx_byte;
			end else begin
				last = 1'b1;
				if ({rx_byte, crclo_b} != crc_b) begin
					status = ST_CRC_ERR;
				end else begin
					status = exc_n ? ST_EXC_OK : ST_OK;
				end
			end
		end else begin
			crc_n = crc_byte(crc_b, rx_byte);
		end

		res.byte_out       = rx_byte;
		res.byte_index     = pos;
		res.frame_last     = last;
		res.frame_status   = status;
		res.slave_address  = slave_n;
		res.function_code  = fn_n;
		res.exception_flag = exc_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			exp_q   <= '0;
			crc_q   <= CRC_INIT;
			slave_q <= '0;
			fn_q    <= '0;
			exc_q   <= 1'b0;
			crclo_q <= '0;
		end else if (advance) begin
			if (last) begin
				pos_q   <= '0;
				exp_q   <= '0;
				crc_q   <= CRC_INIT;
				slave_q <= '0;
				fn_q    <= '0;
				exc_q   <= 1'b0;
				crclo_q <= '0;
			end else begin
				pos_q   <= pos + PosW'(1);
				exp_q   <= exp_n;
				crc_q   <= crc_n;
				slave_q <= slave_n;
				fn_q    <= fn_n;
				exc_q   <= exc_n;
				crclo_q <= crclo_n;
			end
		end
	end

endmodule

// ----- hw/rtl/modbus_rtu_response_deframer.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_response_deframer
// Modbus RTU response deframer with CRC-16 check and per-byte status.
// ----------------------------------------------------------------------------
// Each accepted byte yields exactly one result, in order, through the input
// register and then the result register. One byte per clock is sustained
// while m_tready is high; the byte-wide unrolled CRC-16 update between the
// two registers sets the critical path. An untaken result holds in the
// result register while the next byte waits in the input register. s_tuser
// bit 0 restarts framing on that byte. The user writes the discard limit for
// unknown functions via cfg_valid/cfg_data between frames; not enforced.
module modbus_rtu_response_deframer
	import mrd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] rx_byte
	input  logic [0:0]        s_tuser,   // [0] restart
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [39:0]       m_tdata,   // [7:0] byte_out, [16:8] byte_index,
	                                     // [24:17] slave_address,
	                                     // [31:25] function_code,
	                                     // [32] exception_flag, [39:33] zero
	output logic              m_tlast,   // frame_last
	output logic [2:0]        m_tuser,   // [2:0] frame_status
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [LimitW-1:0] cfg_data   // unknown_discard_limit
);

	logic [LimitW-1:0] limit_q;
	logic              valid_s1;
	logic [ByteW-1:0]  byte_s1;
	logic              restart_s1;
	logic              valid_s2;
	result_t           res_s2;
	result_t           res;
	logic              advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1    <= s_tdata;
			restart_s1 <= s_tuser[0];
		end
	end

	mrd_frame u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.rx_byte (byte_s1),
		.restart (restart_s1),
		.limit   (limit_q),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tlast  = res_s2.frame_last;
	assign m_tuser  = res_s2.frame_status;
	assign m_tdata  = {7'd0, res_s2.exception_flag, res_s2.function_code,
		res_s2.slave_address, res_s2.byte_index, res_s2.byte_out};

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Modbus RTU response deframer. Sends response
// frames of every function kind, exception and unknown frames, CRC errors,
// restarts and loose noise. Each byte is pushed through a behavioral deframer
// on its transaction, and every result is compared field by field in order.
// ----------------------------------------------------------------------------
module testbench;
	import mrd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic [7:0] EXC_MASK = 8'h80;

	typedef enum {
		FRAME_READ,
		FRAME_WRITE,
		FRAME_EXCEPTION,
		FRAME_UNKNOWN,
		FRAME_NOISE
	} frame_kind_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;   // [7:0] rx_byte
	logic [0:0]        s_tuser;   // [0] restart
	logic              m_tvalid;
	logic              m_tready;
	logic [39:0]       m_tdata;   // [7:0] byte_out, [16:8] byte_index, [24:17] slave_address,
	                              // [31:25] function_code, [32] exception_flag
	logic              m_tlast;   // frame_last
	logic [2:0]        m_tuser;   // [2:0] frame_status
	logic              cfg_valid;
	logic              cfg_ready;
	logic [LimitW-1:0] cfg_data;

	logic [PosW-1:0]   fr_pos;
	logic [PosW-1:0]   fr_len;
	logic [CrcW-1:0]   fr_crc;
	logic [ByteW-1:0]  fr_slave;
	logic [FnW-1:0]    fr_fn;
	logic              fr_exc;
	logic [ByteW-1:0]  fr_crc_lo;
	logic [LimitW-1:0] disc_limit;

	result_t           expected_echoes[$];
	result_t           want;
	logic [7:0]        tx_frame[$];

	int src_idle_pct;
	int snk_stall_pct;
	int mismatches;
	int results_checked;
	int bytes_sent;
	int frames_ok;
	int frames_exc;
	int frames_crc;
	int frames_discarded;
	int cycle_count;

	modbus_rtu_response_deframer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [CrcW-1:0] crc16_update(input logic [CrcW-1:0] crc,
		input logic [7:0] data);
		logic [CrcW-1:0] c;
		c = crc ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic known_function(input logic [FnW-1:0] fn, input logic exc);
		return exc || (fn >= FN_READ_COILS && fn <= FN_READ_INPUTS) ||
			fn == FN_WRITE_COIL || fn == FN_WRITE_REG ||
			fn == FN_WRITE_COILS || fn == FN_WRITE_REGS;
	endfunction

	function automatic logic [LimitW-1:0] effective_limit();
		return (disc_limit < LIMIT_MIN) ? LIMIT_MIN : disc_limit;
	endfunction

	function automatic void clear_frame_state();
		fr_pos = '0;
		fr_len = '0;
		fr_crc = CRC_INIT;
		fr_slave = '0;
		fr_fn = '0;
		fr_exc = 1'b0;
		fr_crc_lo = '0;
	endfunction

	function automatic result_t deframe_byte(input logic [7:0] b, input logic restart);
		result_t r;
		logic [PosW-1:0] pos;
		logic [CrcW-1:0] rx_crc;
		if (restart) begin
			clear_frame_state();
		end
		pos = fr_pos;
		if (pos == 0) begin
			fr_slave = b;
		end else if (pos == 1) begin
			fr_fn = b[6:0];
			fr_exc = (b & EXC_MASK) != 0;
			if (fr_exc) begin
				fr_len = LEN_EXC;
			end else if (fr_fn == FN_WRITE_COIL || fr_fn == FN_WRITE_REG ||
				fr_fn == FN_WRITE_COILS || fr_fn == FN_WRITE_REGS) begin
				fr_len = LEN_FIXED;
			end
		end else if (pos == 2) begin
			if (!fr_exc && fr_fn >= FN_READ_COILS && fr_fn <= FN_READ_INPUTS) begin
				fr_len = {1'b0, b} + LEN_OVERHEAD;
			end
		end
		r.byte_out = b;
		r.byte_index = pos;
		r.slave_address = fr_slave;
		r.function_code = fr_fn;
		r.exception_flag = fr_exc;
		r.frame_last = 1'b0;
		r.frame_status = ST_PROGRESS;
		if (pos >= 1 && !known_function(fr_fn, fr_exc)) begin
			if (pos >= effective_limit()) begin
				r.frame_last = 1'b1;
				r.frame_status = ST_UNKNOWN;
			end
		end else if (fr_len != 0 && int'(pos) + 2 >= int'(fr_len)) begin
			if (int'(pos) + 2 == int'(fr_len)) begin
				fr_crc_lo = b;
			end else begin
				rx_crc = {b, fr_crc_lo};
				r.frame_last = 1'b1;
				if (rx_crc != fr_crc) begin
					r.frame_status = ST_CRC_ERR;
				end else begin
					r.frame_status = fr_exc ? ST_EXC_OK : ST_OK;
				end
			end
		end else begin
			fr_crc = crc16_update(fr_crc, b);
		end
		if (r.frame_last) begin
			clear_frame_state();
		end else begin
			fr_pos = pos + PosW'(1);
		end
		return r;
	endfunction

	function automatic void seal_frame();
		logic [CrcW-1:0] crc;
		crc = CRC_INIT;
		foreach (tx_frame[i]) begin
			crc = crc16_update(crc, tx_frame[i]);
		end
		tx_frame.push_back(crc[7:0]);
		tx_frame.push_back(crc[15:8]);
	endfunction

	function automatic void fill_frame(input frame_kind_t kind, input bit corrupt);
		logic [FnW-1:0] fn;
		int cnt;
		int idx;
		tx_frame.delete();
		tx_frame.push_back(8'($urandom_range(255)));
		case (kind)
			FRAME_READ: begin
				fn = FnW'($urandom_range(FN_READ_COILS, FN_READ_INPUTS));
				cnt = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(12);
				tx_frame.push_back({1'b0, fn});
				tx_frame.push_back(8'(cnt));
				repeat (cnt) tx_frame.push_back(8'($urandom_range(255)));
				seal_frame();
			end
			FRAME_WRITE: begin
				case ($urandom_range(3))
					0: fn = FN_WRITE_COIL;
					1: fn = FN_WRITE_REG;
					2: fn = FN_WRITE_COILS;
					default: fn = FN_WRITE_REGS;
				endcase
				tx_frame.push_back({1'b0, fn});
				repeat (4) tx_frame.push_back(8'($urandom_range(255)));
				seal_frame();
			end
			FRAME_EXCEPTION: begin
				tx_frame.push_back(EXC_MASK | 8'($urandom_range(127)));
				tx_frame.push_back(8'($urandom_range(255)));
				seal_frame();
			end
			FRAME_UNKNOWN: begin
				do fn = FnW'($urandom_range(127)); while (known_function(fn, 1'b0));
				tx_frame.push_back({1'b0, fn});
				while (tx_frame.size() < int'(effective_limit()) + 1) begin
					tx_frame.push_back(8'($urandom_range(255)));
				end
			end
			default: begin
				repeat ($urandom_range(5)) tx_frame.push_back(8'($urandom_range(255)));
			end
		endcase
		if (corrupt && kind != FRAME_UNKNOWN && kind != FRAME_NOISE) begin
			idx = $urandom_range(3, tx_frame.size() - 1);
			tx_frame[idx] = tx_frame[idx] ^ 8'($urandom_range(1, 255));
		end
	endfunction

	function automatic void check_field(input string name, input logic [15:0] exp_v,
		input logic [15:0] got_v);
		if (exp_v !== got_v) begin
			mismatches++;
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic restart);
		result_t got;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= restart;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		got = deframe_byte(b, restart);
		expected_echoes.push_back(got);
		bytes_sent++;
		case (got.frame_status)
			ST_OK: frames_ok++;
			ST_EXC_OK: frames_exc++;
			ST_CRC_ERR: frames_crc++;
			ST_UNKNOWN: frames_discarded++;
			default: ;
		endcase
	endtask

	task automatic send_frame(input logic restart_first);
		int i;
		for (i = 0; i < tx_frame.size(); i++) begin
			send_byte(tx_frame[i], (i == 0) && restart_first);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_echoes.size() != 0) @(posedge clk);
	endtask

	task automatic write_discard_limit(input logic [LimitW-1:0] value);
		if (fr_pos != 0) begin
			fill_frame(FRAME_EXCEPTION, 1'b0);
			send_frame(1'b1);
		end
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		disc_limit = value;
	endtask

	task automatic test_basic_frames();
		tx_frame = '{8'h00, 8'h03, 8'h00};
		seal_frame();
		send_frame(1'b0);
		tx_frame = '{8'hFF, 8'h83, 8'h02};
		seal_frame();
		send_frame(1'b0);
		tx_frame = '{8'h11, 8'h10, 8'h00, 8'h01, 8'h00, 8'h02};
		seal_frame();
		send_frame(1'b0);
		tx_frame = '{8'h7E, 8'h01, 8'h01, 8'hFF};
		seal_frame();
		send_frame(1'b0);
		wait_drained();
	endtask

	task automatic test_crc_errors();
		tx_frame = '{8'h22, 8'h84, 8'h01};
		seal_frame();
		tx_frame[4] = tx_frame[4] ^ 8'h01;
		send_frame(1'b0);
		wait_drained();
	endtask

	task automatic test_restart();
		tx_frame = '{8'h05, 8'h05, 8'h00};
		send_frame(1'b0);
		tx_frame = '{8'h31, 8'h86, 8'h03};
		seal_frame();
		send_frame(1'b1);
		wait_drained();
	endtask

	task automatic test_discard_limits();
		logic [LimitW-1:0] limits[3];
		limits = '{9'd0, 9'd2, 9'd8};
		fill_frame(FRAME_UNKNOWN, 1'b0);
		send_frame(1'b0);
		foreach (limits[i]) begin
			write_discard_limit(limits[i]);
			fill_frame(FRAME_UNKNOWN, 1'b0);
			send_frame(1'b0);
		end
		wait_drained();
	endtask

	task automatic test_long_read();
		src_idle_pct = 22;
		snk_stall_pct = 22;
		tx_frame = '{8'h42, {1'b0, FN_READ_INPUTS}, 8'hFF};
		repeat (255) tx_frame.push_back(8'($urandom_range(255)));
		seal_frame();
		send_frame(1'b1);
		src_idle_pct = 0;
		snk_stall_pct = 0;
		wait_drained();
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
		input logic [LimitW-1:0] limit_value, input int n_bytes);
		int start;
		int r;
		int cut;
		int i;
		logic restart_next;
		frame_kind_t kind;
		write_discard_limit(limit_value);
		src_idle_pct = idle_pct;
		snk_stall_pct = stall_pct;
		start = bytes_sent;
		restart_next = 1'b0;
		while (bytes_sent - start < n_bytes) begin
			r = $urandom_range(99);
			if (r < 42) kind = FRAME_READ;
			else if (r < 68) kind = FRAME_WRITE;
			else if (r < 82) kind = FRAME_EXCEPTION;
			else if (r < 90) kind = FRAME_UNKNOWN;
			else kind = FRAME_NOISE;
			fill_frame(kind, $urandom_range(99) < 15);
			if ($urandom_range(19) == 0) begin
				wait_drained();
			end
			if (kind == FRAME_NOISE) begin
				foreach (tx_frame[j]) send_byte(tx_frame[j], 1'($urandom_range(1)));
				restart_next = 1'b1;
			end else begin
				cut = tx_frame.size();
				if ($urandom_range(99) < 8) begin
					cut = $urandom_range(1, tx_frame.size() - 1);
				end
				for (i = 0; i < cut; i++) begin
					send_byte(tx_frame[i], (i == 0) && (restart_next || $urandom_range(1)));
				end
				restart_next = cut < tx_frame.size();
			end
		end
		src_idle_pct = 0;
		snk_stall_pct = 0;
		wait_drained();
	endtask

	always @(posedge clk) begin
		m_tready <= $urandom_range(99) >= snk_stall_pct;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_echoes.size() == 0) begin
				mismatches++;
				$display("%0t ns: result with nothing expected, data %h last %b status %0d",
					$time, m_tdata, m_tlast, m_tuser);
			end else begin
				want = expected_echoes.pop_front();
				check_field("byte_out", 16'(want.byte_out), 16'(m_tdata[7:0]));
				check_field("byte_index", 16'(want.byte_index), 16'(m_tdata[16:8]));
				check_field("slave_address", 16'(want.slave_address), 16'(m_tdata[24:17]));
				check_field("function_code", 16'(want.function_code), 16'(m_tdata[31:25]));
				check_field("exception_flag", 16'(want.exception_flag), 16'(m_tdata[32]));
				check_field("frame_last", 16'(want.frame_last), 16'(m_tlast));
				check_field("frame_status", 16'(want.frame_status), 16'(m_tuser));
			end
			results_checked++;
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles, %0d results outstanding",
			cycle_count, expected_echoes.size());
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		m_tready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		mismatches = 0;
		results_checked = 0;
		bytes_sent = 0;
		frames_ok = 0;
		frames_exc = 0;
		frames_crc = 0;
		frames_discarded = 0;
		disc_limit = LIMIT_RESET;
		clear_frame_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_frames();
		test_crc_errors();
		test_restart();
		test_discard_limits();
		test_long_read();
		test_random_traffic(0, 0, 9'($urandom_range(8, 24)), 60);
		test_random_traffic(83, 0, 9'd0, 60);
		test_random_traffic(0, 83, 9'($urandom_range(8, 16)), 60);
		test_random_traffic(22, 22, 9'($urandom_range(8, 30)), 60);

		wait_drained();
		repeat (16) @(posedge clk);
		$display("Sent %0d bytes of directed and random RTU traffic, %0d results checked",
			bytes_sent, results_checked);
		$display("Frames ended: %0d ok, %0d exception, %0d crc error, %0d discarded",
			frames_ok, frames_exc, frames_crc, frames_discarded);
		if (mismatches == 0 && expected_echoes.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- modbus_rtu_response_deframer.f -----
hw/rtl/mrd_pkg.sv
hw/rtl/mrd_frame.sv
hw/rtl/modbus_rtu_response_deframer.sv
tb/sv/testbench.sv
